[rtl/core/urr32_pkg.sv]
// urr32_pkg: types and constants shared by the uniform range generator
// used by urr32_ctrl, urr32_dp and the top level
`timescale 1ns / 1ps
package urr32_pkg;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LIM,
        ST_LIM_WAIT,
        ST_DRAW,
        ST_DIV_MOD,
        ST_MOD_WAIT,
        ST_ADV,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic seed_load;
        logic div_start;
        logic div_mod;
        logic step_draw;
        logic step_adv;
        logic set_min;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty_range;
        logic div_done;
        logic draw_ok;
        logic adv_ok;
    } t_stat;

    function automatic logic [31:0] xs_next(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage

[rtl/core/urr32_dp.sv]
// urr32_dp: generator state, operand registers, shared restoring divider
// depends on urr32_pkg
`timescale 1ns / 1ps
module urr32_dp
    import urr32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_req_type,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_min,
    input  logic [31:0] i_range_max,
    output t_stat       o_stat,
    output logic        o_is_reseed,
    output logic [31:0] o_result
);
    logic [31:0] r_state, r_min, r_max, r_range, r_limit, r_draw, r_adv, r_res;
    logic [31:0] r_seed;
    logic        r_reseed;
    // divider registers
    logic [31:0] r_quo, r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;
    logic [31:0] w_xd, w_xa;

    assign w_xd    = xs_next(r_draw);
    assign w_xa    = xs_next(r_adv);
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_range};

    // operand capture and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_cmd.seed_load) begin
            r_state <= r_seed;
        end else if (i_cmd.step_adv && w_xa != ALL_ONES) begin
            r_state <= w_xa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_reseed <= i_req_type;
            r_seed   <= i_seed_value;
            r_min    <= i_range_min;
            r_max    <= i_range_max;
            r_range  <= i_range_max - i_range_min;
            r_draw   <= r_state;
            r_adv    <= r_state;
        end
        if (i_cmd.step_draw) begin
            r_draw <= w_xd;
        end
        if (i_cmd.step_adv) begin
            r_adv <= w_xa;
        end
        if (i_cmd.set_min) begin
            r_res <= r_min;
        end else if (!r_busy && r_cnt == 6'd32 && i_cmd.div_mod) begin
            r_res <= r_rem + r_min;
        end
        // all ones = quotient * range + remainder, so limit = all ones - remainder
        if (!r_busy && r_cnt == 6'd32 && !i_cmd.div_mod) begin
            r_limit <= ALL_ONES - r_rem;
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_cmd.div_mod ? r_draw : ALL_ONES;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end else if (r_cnt == 6'd32) begin
            r_cnt <= '0;
        end
    end

    assign o_stat.empty_range = r_min >= r_max;
    assign o_stat.div_done    = !r_busy && r_cnt == 6'd32;
    assign o_stat.draw_ok     = w_xd < r_limit;
    assign o_stat.adv_ok      = w_xa != ALL_ONES;
    assign o_is_reseed        = r_reseed;
    assign o_result           = r_res;
endmodule

[rtl/core/urr32_ctrl.sv]
// urr32_ctrl: sequencing state machine for reseed and draw requests
// depends on urr32_pkg
`timescale 1ns / 1ps
module urr32_ctrl
    import urr32_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    input  logic  i_is_reseed,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_DIV_LIM;
                end
            end
            ST_DIV_LIM: begin
                if (i_is_reseed) begin
                    o_cmd.seed_load = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_stat.empty_range) begin
                    o_cmd.set_min = 1'b1;
                    n_state       = ST_ADV;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_LIM_WAIT;
                end
            end
            // limit is registered at the edge that ends this wait
            ST_LIM_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                o_cmd.step_draw = 1'b1;
                if (i_stat.draw_ok) begin
                    n_state = ST_DIV_MOD;
                end
            end
            ST_DIV_MOD: begin
                o_cmd.div_mod   = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_MOD_WAIT;
            end
            // remainder plus minimum is registered at the end of this wait
            ST_MOD_WAIT: begin
                o_cmd.div_mod = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV: begin
                o_cmd.step_adv = 1'b1;
                if (i_stat.adv_ok) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[rtl/core/uniform_range_random_32.sv]
// uniform_range_random_32: top level, controller plus datapath
// depends on urr32_pkg, urr32_ctrl, urr32_dp
//
// Usage:
//  - input channel i_in_valid/o_in_ready carries one request item:
//    req_type 1 reseeds the xorshift state and gives no result,
//    req_type 0 draws one value in [range_min, range_max), or range_min when range_min >= range_max.
//  - output channel o_out_valid/i_out_ready carries one random_value
//    item per draw.
//  - a draw runs the limit division, N >= 1 rejection steps, the
//    remainder division and M >= 1 state advance steps (almost always
//    1); an empty range skips both divisions and the rejection loop.
//    A reseed loads the seed in ST_DIV_LIM, then the block is ready
//    again.
//  - one item is in flight at a time; ready returns the cycle after the
//    result is taken. The serial divider makes one quotient bit a cycle.
//  - reset clears the generator state to zero; a zero state gives
//    range_min on every draw until reseeded.
//  - when the receiver stalls the result holds and no new item is taken.
`timescale 1ns / 1ps
module uniform_range_random_32
    import urr32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_min,
    input  logic [31:0] i_range_max,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_random_value
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_is_reseed;

    urr32_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .i_is_reseed (w_is_reseed),
        .o_cmd       (w_cmd)
    );

    urr32_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_type   (i_req_type),
        .i_seed_value (i_seed_value),
        .i_range_min  (i_range_min),
        .i_range_max  (i_range_max),
        .o_stat       (w_stat),
        .o_is_reseed  (w_is_reseed),
        .o_result     (o_random_value)
    );
endmodule

[rtl/core/urr32_checker.sv]
// urr32_props: port-level checks for the uniform range generator
// depends on uniform_range_random_32 (bound below)
`timescale 1ns / 1ps
module urr32_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_random_value
);
    // one item at a time: never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_random_value))
        else $error("result changed under stall");

    // an accepted item drops ready next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("ready after accept");

    // after a delivered result the block is ready again
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> o_in_ready) else $error("not ready after output");
endmodule

bind uniform_range_random_32 urr32_props u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_random_value (o_random_value)
);

[tb/sv/urr32_checker.sv]
// urr32_checker: watches both channels of the uniform range generator,
// predicts each drawn value and compares it; depends on nothing but the ports
`timescale 1ns / 1ps
module urr32_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_min,
    input  logic [31:0] i_range_max,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_random_value,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_draw_count
);
    localparam logic REQ_RESEED = 1'b1;
    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

    logic [31:0] gen_word;
    logic [31:0] value_queue[$];

    // one xorshift step, shifts 13, 17, 5
    function automatic logic [31:0] shift_mix(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // rejection sampling of successive xorshift values into [lo, hi), or lo for an empty range
    function automatic logic [31:0] sample_range(input logic [31:0] s,
                                                 input logic [31:0] lo,
                                                 input logic [31:0] hi);
        logic [31:0] span;
        logic [31:0] ceiling;
        if (lo >= hi) return lo;
        span    = hi - lo;
        ceiling = (WORD_MAX / span) * span;
        do begin
            s = shift_mix(s);
        end while (s >= ceiling);
        return (s % span) + lo;
    endfunction

    assign o_pending = value_queue.size();

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_word = '0;
            value_queue.delete();
            o_fail_count <= 0;
            o_draw_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_RESEED) begin
                    gen_word = i_seed_value;
                end else begin
                    value_queue.push_back(sample_range(gen_word, i_range_min, i_range_max));
                    gen_word = sample_range(gen_word, 32'd0, WORD_MAX);
                end
            end
            if (i_out_valid && i_out_ready) begin
                o_draw_count <= o_draw_count + 1;
                if (value_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t unexpected result %h", $realtime, i_random_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    logic [31:0] want;
                    want = value_queue.pop_front();
                    if (want !== i_random_value) begin
                        if (o_fail_count < 10)
                            $display("%0t random_value mismatch: expected %h got %h",
                                     $realtime, want, i_random_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/sv/testbench.sv]
// testbench: stimulus and verdict for uniform_range_random_32
// depends on the rtl top level and urr32_checker
`timescale 1ns / 1ps
module testbench;
    localparam logic REQ_DRAW   = 1'b0;
    localparam logic REQ_RESEED = 1'b1;
    localparam int   RANDOM_ITEMS = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = REQ_DRAW;
    logic [31:0] i_seed_value = '0;
    logic [31:0] i_range_min = '0;
    logic [31:0] i_range_max = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_random_value;

    int fail_count;
    int pending;
    int draw_count;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int reseed_count = 0;

    uniform_range_random_32 u_top (.*);

    urr32_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_seed_value(i_seed_value),
        .i_range_min(i_range_min), .i_range_max(i_range_max),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_random_value(o_random_value),
        .o_fail_count(fail_count), .o_pending(pending), .o_draw_count(draw_count)
    );

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    // offer one item and wait for it to be taken
    task automatic offer(input logic req, input logic [31:0] seed,
                         input logic [31:0] lo, input logic [31:0] hi);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_seed_value <= seed;
        i_range_min  <= lo;
        i_range_max  <= hi;
        if (req == REQ_RESEED) reseed_count++;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic draw(input logic [31:0] lo, input logic [31:0] hi);
        offer(REQ_DRAW, $urandom(), lo, hi);
    endtask

    task automatic reseed(input logic [31:0] seed);
        offer(REQ_RESEED, seed, $urandom(), $urandom());
    endtask

    // random draw with a spread of range shapes
    task automatic random_draw();
        logic [31:0] lo;
        logic [31:0] hi;
        int pick;
        pick = $urandom_range(99);
        lo = $urandom();
        if (pick < 30) hi = lo + $urandom_range(1, 100);
        else if (pick < 55) hi = $urandom();
        else if (pick < 65) hi = lo - $urandom_range(0, 3);
        else if (pick < 80) begin
            lo = $urandom_range(0, 1000);
            hi = lo + 32'h8000_0000 + $urandom_range(1, 64);
        end else if (pick < 90) begin
            lo = 32'd0;
            hi = 32'hFFFF_FFFF - $urandom_range(0, 2);
        end else hi = lo + $urandom_range(1, 32'h00FF_FFFF);
        draw(lo, hi);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero state, extremes, empty and inverted ranges
        draw(32'd5, 32'd10);
        draw(32'd0, 32'hFFFF_FFFF);
        reseed(32'd1);
        draw(32'd0, 32'hFFFF_FFFF);
        draw(32'hFFFF_FFFF, 32'd0);
        draw(32'd7, 32'd7);
        draw(32'd0, 32'd1);
        draw(32'd0, 32'h8000_0001);
        draw(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        draw(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        reseed(32'hFFFF_FFFF);
        draw(32'd0, 32'd3);
        draw(32'd100, 32'd200);
        reseed(32'h8000_0000);
        draw(32'd0, 32'hFFFF_FFFF);
        reseed(32'd0);
        draw(32'd1, 32'd9);
        reseed(32'hDEAD_BEEF);
        draw(32'd0, 32'h8000_0001);
        draw(32'h5555_5555, 32'hAAAA_AAAA);

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 200) hold_request = 1'b1;
            // sender goes quiet until every result is back
            if (n == 800) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait (pending == 0);
            end
            if ($urandom_range(99) < 10)
                reseed(($urandom_range(49) == 0) ? 32'd0 : $urandom());
            else
                random_draw();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d draws checked, %0d reseeds, including zero and all-ones seeds,",
                 draw_count, reseed_count);
        $display("empty, inverted, unit, full and high-rejection ranges, with stalls and gaps");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/core/urr32_pkg.sv
rtl/core/urr32_dp.sv
rtl/core/urr32_ctrl.sv
rtl/core/uniform_range_random_32.sv
rtl/core/urr32_checker.sv
tb/sv/urr32_checker.sv
tb/sv/testbench.sv
